// ----- rtl/core/p2s_pkg.sv -----
// Shared constants and types for the 2x2 stride-2 int8 pooling block.
`timescale 1ns / 1ps
package p2s_pkg;

  localparam int PIX_W   = 8;
  localparam int STORE_W = 10;
  localparam int SUM_W   = STORE_W + 1;

  localparam int MODE_W  = 1;
  localparam int WIDTH_W = 8;
  localparam int HEIGHT_W = 11;
  localparam int CHAN_W  = 7;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd3;

  localparam logic MODE_MAX = 1'b0;
  localparam logic MODE_AVG = 1'b1;

  localparam int DEF_MAX_WIDTH    = 128;
  localparam int DEF_MAX_CHANNELS = 64;
  localparam int DEF_MAX_HEIGHT   = 1024;

  localparam int PIX_MIN      = -128;
  localparam int PIX_MAX      = 127;
  localparam int AVG_PIX_MIN  = -127;
  localparam int SUM_MIN      = -512;
  localparam int SUM_MAX      = 511;
  localparam int AVG_ROUND    = 2;

  typedef struct packed {
    logic start;
    logic emit;
    logic last;
  } pos_flags_t;

endpackage

// ----- rtl/core/p2s_in_if.sv -----
// Input stream channel: one signed tensor element per transfer.
`timescale 1ns / 1ps
interface p2s_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [p2s_pkg::PIX_W-1:0]  pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

// ----- rtl/core/p2s_out_if.sv -----
// Result stream channel: one pooled value and frame end flag per transfer.
`timescale 1ns / 1ps
interface p2s_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [p2s_pkg::PIX_W-1:0]  result_value;
  logic                              frame_last;

  modport source (output valid, output result_value, output frame_last, input ready);
  modport sink (input valid, input result_value, input frame_last, output ready);
endinterface

// ----- rtl/core/p2s_pos.sv -----
// Channel, column and row position counters with store address and window flags.
`timescale 1ns / 1ps
module p2s_pos #(
  parameter int MAX_WIDTH    = p2s_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = p2s_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_HEIGHT   = p2s_pkg::DEF_MAX_HEIGHT,
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int DEPTH  = (MAX_WIDTH / 2) * MAX_CHANNELS,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  logic [COL_W:0]        w_lim,
  input  logic [ROW_W:0]        h_lim,
  input  logic [CH_W:0]         c_lim,
  output logic [ADDR_W-1:0]     addr,
  output p2s_pkg::pos_flags_t   flags
);

  logic [CH_W-1:0]  ch_r, ch_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             last_ch, last_col, last_row;

  assign last_ch  = ({1'b0, ch_r} + (CH_W + 1)'(1)) >= c_lim;
  assign last_col = ({1'b0, col_r} + (COL_W + 1)'(1)) >= w_lim;
  assign last_row = ({1'b0, row_r} + (ROW_W + 1)'(1)) >= h_lim;

  assign addr = ADDR_W'(col_r >> 1) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(ch_r);

  assign flags.start = !row_r[0] && !col_r[0];
  assign flags.emit  = row_r[0] && col_r[0];
  assign flags.last  = last_ch && last_col && last_row;

  always_comb begin
    ch_nxt  = ch_r;
    col_nxt = col_r;
    row_nxt = row_r;
    if (!last_ch) begin
      ch_nxt = ch_r + CH_W'(1);
    end else begin
      ch_nxt = '0;
      if (!last_col) begin
        col_nxt = col_r + COL_W'(1);
      end else begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r  <= '0;
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      ch_r  <= ch_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ----- rtl/core/p2s_store.sv -----
// Partial window store: synchronous memory with write-to-read forwarding.
`timescale 1ns / 1ps
module p2s_store #(
  parameter int MAX_WIDTH    = p2s_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = p2s_pkg::DEF_MAX_CHANNELS,
  localparam int DEPTH  = (MAX_WIDTH / 2) * MAX_CHANNELS,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                rd_en,
  input  logic [ADDR_W-1:0]                   rd_addr,
  output logic signed [p2s_pkg::STORE_W-1:0]  rd_data,
  input  logic                                wr_en,
  input  logic [ADDR_W-1:0]                   wr_addr,
  input  logic signed [p2s_pkg::STORE_W-1:0]  wr_data
);

  logic signed [p2s_pkg::STORE_W-1:0] mem [DEPTH];
  logic signed [p2s_pkg::STORE_W-1:0] q_r;
  logic [ADDR_W-1:0]                  rd_addr_r;
  logic [ADDR_W-1:0]                  wr_addr_r;
  logic signed [p2s_pkg::STORE_W-1:0] wr_data_r;
  logic                               wr_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r       <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_valid_r <= 1'b0;
    end else if (wr_en) begin
      wr_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wr_addr_r <= wr_addr;
      wr_data_r <= wr_data;
    end
  end

  // latest write wins over a read that raced it
  assign rd_data = (wr_valid_r && (wr_addr_r == rd_addr_r)) ? wr_data_r : q_r;

endmodule

// ----- rtl/core/pool_2x2_stream_int8.sv -----
// Top level of the streaming 2x2 stride-2 int8 max/average pooling block.
// Path: the element that closes a window is registered in the combine stage, then its result in
//   the output register, before the result can transfer.
// Throughput: one element per cycle unless stalled; the store read-modify-write loop is one read,
//   one combine, one write, the last write forwarded to the following read of the same entry.
// Stalls: input held only while a closing element waits behind a result the sink has not taken.
// Reset: clears counters, pipeline valids and config registers; store stays undefined, no sweep.
`timescale 1ns / 1ps
module pool_2x2_stream_int8 #(
  parameter int MAX_WIDTH    = p2s_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = p2s_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_HEIGHT   = p2s_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  p2s_in_if.sink                               in_if,
  p2s_out_if.source                            out_if,
  input  logic                                 cfg_we,
  input  logic [p2s_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [p2s_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DEPTH  = (MAX_WIDTH / 2) * MAX_CHANNELS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PIX_W  = p2s_pkg::PIX_W;
  localparam int STORE_W = p2s_pkg::STORE_W;
  localparam int SUM_W  = p2s_pkg::SUM_W;

  logic [p2s_pkg::MODE_W-1:0]   pool_mode_r;
  logic [p2s_pkg::WIDTH_W-1:0]  image_width_r;
  logic [p2s_pkg::HEIGHT_W-1:0] image_height_r;
  logic [p2s_pkg::CHAN_W-1:0]   channel_count_r;

  logic [COL_W:0] w_raw, w_lim;
  logic [ROW_W:0] h_raw, h_lim;
  logic [CH_W:0]  c_lim;

  logic                      in_fire;
  logic [ADDR_W-1:0]         pos_addr;
  p2s_pkg::pos_flags_t       pos_flags;

  logic                      s1_valid_r;
  logic signed [PIX_W-1:0]   s1_x_r;
  logic [ADDR_W-1:0]         s1_addr_r;
  p2s_pkg::pos_flags_t       s1_flags_r;
  logic                      s1_fire;

  logic signed [STORE_W-1:0] prev;
  logic signed [STORE_W-1:0] x_ext;
  logic signed [SUM_W-1:0]   sum;
  logic signed [STORE_W-1:0] acc;
  logic signed [SUM_W-1:0]   avg_v;
  logic signed [SUM_W-1:0]   avg_q;
  logic signed [PIX_W-1:0]   result;

  logic                      out_valid_r;
  logic signed [PIX_W-1:0]   out_value_r;
  logic                      out_last_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_mode_r     <= p2s_pkg::MODE_MAX;
      image_width_r   <= p2s_pkg::WIDTH_W'(2);
      image_height_r  <= p2s_pkg::HEIGHT_W'(2);
      channel_count_r <= p2s_pkg::CHAN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        p2s_pkg::REG_POOL_MODE: begin
          pool_mode_r <= cfg_wdata[p2s_pkg::MODE_W-1:0];
        end
        p2s_pkg::REG_IMAGE_WIDTH: begin
          image_width_r <= cfg_wdata[p2s_pkg::WIDTH_W-1:0];
        end
        p2s_pkg::REG_IMAGE_HEIGHT: begin
          image_height_r <= cfg_wdata[p2s_pkg::HEIGHT_W-1:0];
        end
        p2s_pkg::REG_CHANNEL_COUNT: begin
          channel_count_r <= cfg_wdata[p2s_pkg::CHAN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // clamp geometry to the supported range and round width and height down to even
  always_comb begin
    if (32'(image_width_r) < 32'd2) begin
      w_raw = (COL_W + 1)'(2);
    end else if (32'(image_width_r) > 32'(MAX_WIDTH)) begin
      w_raw = (COL_W + 1)'(MAX_WIDTH);
    end else begin
      w_raw = (COL_W + 1)'(image_width_r);
    end
    w_lim = {w_raw[COL_W:1], 1'b0};

    if (32'(image_height_r) < 32'd2) begin
      h_raw = (ROW_W + 1)'(2);
    end else if (32'(image_height_r) > 32'(MAX_HEIGHT)) begin
      h_raw = (ROW_W + 1)'(MAX_HEIGHT);
    end else begin
      h_raw = (ROW_W + 1)'(image_height_r);
    end
    h_lim = {h_raw[ROW_W:1], 1'b0};

    if (32'(channel_count_r) < 32'd1) begin
      c_lim = (CH_W + 1)'(1);
    end else if (32'(channel_count_r) > 32'(MAX_CHANNELS)) begin
      c_lim = (CH_W + 1)'(MAX_CHANNELS);
    end else begin
      c_lim = (CH_W + 1)'(channel_count_r);
    end
  end

  assign s1_fire     = s1_valid_r && (!s1_flags_r.emit || !out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_fire;
  assign in_fire     = in_if.valid && in_if.ready;

  p2s_pos #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_HEIGHT   (MAX_HEIGHT)
  ) u_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_fire),
    .w_lim   (w_lim),
    .h_lim   (h_lim),
    .c_lim   (c_lim),
    .addr    (pos_addr),
    .flags   (pos_flags)
  );

  p2s_store #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (pos_addr),
    .rd_data (prev),
    .wr_en   (s1_fire),
    .wr_addr (s1_addr_r),
    .wr_data (acc)
  );

  // combine stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_x_r     <= in_if.pixel_value;
      s1_addr_r  <= pos_addr;
      s1_flags_r <= pos_flags;
    end
  end

  assign x_ext = STORE_W'(s1_x_r);
  assign sum   = SUM_W'(prev) + SUM_W'(s1_x_r);

  always_comb begin
    if (s1_flags_r.start) begin
      acc = x_ext;
    end else if (pool_mode_r == p2s_pkg::MODE_MAX) begin
      acc = (x_ext > prev) ? x_ext : prev;
    end else if (sum > p2s_pkg::SUM_MAX) begin
      acc = STORE_W'(p2s_pkg::SUM_MAX);
    end else if (sum < p2s_pkg::SUM_MIN) begin
      acc = STORE_W'(p2s_pkg::SUM_MIN);
    end else begin
      acc = STORE_W'(sum);
    end
  end

  assign avg_v = SUM_W'(acc) + SUM_W'(p2s_pkg::AVG_ROUND);
  assign avg_q = avg_v >>> 2;

  always_comb begin
    if (pool_mode_r == p2s_pkg::MODE_MAX) begin
      if (acc > p2s_pkg::PIX_MAX) begin
        result = PIX_W'(p2s_pkg::PIX_MAX);
      end else if (acc < p2s_pkg::PIX_MIN) begin
        result = PIX_W'(p2s_pkg::PIX_MIN);
      end else begin
        result = PIX_W'(acc);
      end
    end else begin
      if (avg_q > p2s_pkg::PIX_MAX) begin
        result = PIX_W'(p2s_pkg::PIX_MAX);
      end else if (avg_q <= p2s_pkg::PIX_MIN) begin
        result = PIX_W'(p2s_pkg::AVG_PIX_MIN);
      end else begin
        result = PIX_W'(avg_q);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_flags_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_flags_r.emit) begin
      out_value_r <= result;
      out_last_r  <= s1_flags_r.last;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.result_value = out_value_r;
  assign out_if.frame_last   = out_last_r;

  a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |-> (out_valid_r && !out_if.ready && s1_flags_r.emit))
    else $error("combine stage stalled without a blocked result");

  a_ready_when_output_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_valid_r || !out_valid_r) |-> in_if.ready)
    else $error("input held off while the pipeline had room");

  a_emit_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_flags_r.emit) |=> out_valid_r)
    else $error("closed window did not produce a result");

endmodule

// ----- dv/tb_pool_2x2_stream_int8.sv -----
// Self-checking testbench for the streaming 2x2 stride-2 int8 pooling block.
`timescale 1ns / 1ps
module tb_pool_2x2_stream_int8;

  localparam int PIX_W       = p2s_pkg::PIX_W;
  localparam int STORE_W     = p2s_pkg::STORE_W;
  localparam int LONG_HOLD   = 300;
  localparam int STORE_DEPTH = p2s_pkg::DEF_MAX_WIDTH / 2 * p2s_pkg::DEF_MAX_CHANNELS;

  typedef struct packed {
    logic signed [PIX_W-1:0] value;
    logic                    last;
  } pooled_t;

  logic                               clk;
  logic                               rst_n;
  logic                               cfg_we;
  logic [p2s_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [p2s_pkg::CFG_DATA_W-1:0]     cfg_wdata;

  p2s_in_if  in_ch();
  p2s_out_if out_ch();

  pool_2x2_stream_int8 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic                           mode_r   = p2s_pkg::MODE_MAX;
  logic [p2s_pkg::WIDTH_W-1:0]    width_r  = p2s_pkg::WIDTH_W'(2);
  logic [p2s_pkg::HEIGHT_W-1:0]   height_r = p2s_pkg::HEIGHT_W'(2);
  logic [p2s_pkg::CHAN_W-1:0]     chans_r  = p2s_pkg::CHAN_W'(1);

  logic signed [STORE_W-1:0] part_store [STORE_DEPTH];
  logic [5:0]                ch_pos  = '0;
  logic [6:0]                col_pos = '0;
  logic [9:0]                row_pos = '0;

  logic signed [PIX_W-1:0] pixel_queue [$];
  pooled_t                 pooled_expect [$];
  int                      pixels_sent  = 0;
  int                      pixels_taken = 0;
  int                      mismatch_count = 0;
  int                      send_idle_pct  = 0;
  int                      recv_stall_pct = 0;
  logic                    hold_req = 1'b0;
  int                      stall_left = 0;

  int seed_max [8] = '{-128, -128, -128, -128, 127, -128, -128, -128};
  int seed_avg [16] = '{-128, -128, -128, -128, 127, 127, 127, 127,
                        1, 0, 0, 0, -3, 0, 0, 0};
  int send_pcts [4]  = '{0, 50, 0, 26};
  int stall_pcts [4] = '{0, 0, 50, 26};

  function automatic int clip(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int eff_width(int raw);
    return clip(raw, 2, p2s_pkg::DEF_MAX_WIDTH) & ~1;
  endfunction

  function automatic int eff_height(int raw);
    return clip(raw, 2, p2s_pkg::DEF_MAX_HEIGHT) & ~1;
  endfunction

  function automatic int eff_chans(int raw);
    return clip(raw, 1, p2s_pkg::DEF_MAX_CHANNELS);
  endfunction

  function automatic void fold_pixel(logic signed [PIX_W-1:0] px);
    int      w, h, c, slot, acc, prev, pooled;
    bit      last_ch, last_col, last_row;
    pooled_t res;
    w = eff_width(int'(width_r));
    h = eff_height(int'(height_r));
    c = eff_chans(int'(chans_r));
    slot = int'(col_pos >> 1) * p2s_pkg::DEF_MAX_CHANNELS + int'(ch_pos);
    last_ch  = int'(ch_pos) + 1 >= c;
    last_col = int'(col_pos) + 1 >= w;
    last_row = int'(row_pos) + 1 >= h;
    if (!row_pos[0] && !col_pos[0]) begin
      acc = int'(px);
    end else begin
      prev = int'(part_store[slot]);
      if (mode_r == p2s_pkg::MODE_MAX) acc = (int'(px) > prev) ? int'(px) : prev;
      else acc = clip(prev + int'(px), p2s_pkg::SUM_MIN, p2s_pkg::SUM_MAX);
    end
    part_store[slot] = STORE_W'(acc);
    if (row_pos[0] && col_pos[0]) begin
      if (mode_r == p2s_pkg::MODE_MAX) begin
        pooled = clip(acc, p2s_pkg::PIX_MIN, p2s_pkg::PIX_MAX);
      end else begin
        pooled = clip((acc + p2s_pkg::AVG_ROUND) >>> 2, p2s_pkg::PIX_MIN, p2s_pkg::PIX_MAX);
        if (pooled == p2s_pkg::PIX_MIN) pooled = p2s_pkg::AVG_PIX_MIN;
      end
      res.value = PIX_W'(pooled);
      res.last  = last_ch && last_col && last_row;
      pooled_expect.push_back(res);
    end
    if (!last_ch) begin
      ch_pos = ch_pos + 6'd1;
    end else begin
      ch_pos = '0;
      if (!last_col) begin
        col_pos = col_pos + 7'd1;
      end else begin
        col_pos = '0;
        row_pos = last_row ? '0 : row_pos + 10'd1;
      end
    end
  endfunction

  function automatic logic signed [PIX_W-1:0] rand_pixel();
    case ($urandom_range(7))
      0: return PIX_W'(p2s_pkg::PIX_MIN);
      1: return PIX_W'(p2s_pkg::PIX_MAX);
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  task automatic report_error(string note, pooled_t want, pooled_t got);
    if (mismatch_count < 10)
      $display("mismatch (%0s): expected value %0d last %0b, got value %0d last %0b",
               note, want.value, want.last, got.value, got.last);
    mismatch_count++;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // input driver: hold the offered element until its transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        fold_pixel(in_ch.pixel_value);
        pixels_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid       <= 1'b1;
          in_ch.pixel_value <= pixel_queue.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin
    pooled_t got;
    pooled_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.result_value, out_ch.frame_last};
        if (pooled_expect.size() == 0) begin
          want = 'x;
          report_error("no result expected", want, got);
        end else begin
          want = pooled_expect.pop_front();
          if (got.value !== want.value || got.last !== want.last)
            report_error("wrong result", want, got);
        end
      end
      if (hold_req) stall_left <= LONG_HOLD;
      else if (stall_left != 0) stall_left <= stall_left - 1;
      out_ch.ready <= !hold_req && stall_left == 0 && $urandom_range(99) >= recv_stall_pct;
    end
  end

  task automatic push_pixel(logic signed [PIX_W-1:0] px);
    pixel_queue.push_back(px);
    pixels_sent++;
  endtask

  task automatic drain();
    while (pixels_taken != pixels_sent || pooled_expect.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [p2s_pkg::CFG_IDX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[p2s_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      p2s_pkg::REG_POOL_MODE:     mode_r   = value[0];
      p2s_pkg::REG_IMAGE_WIDTH:   width_r  = value[p2s_pkg::WIDTH_W-1:0];
      p2s_pkg::REG_IMAGE_HEIGHT:  height_r = value[p2s_pkg::HEIGHT_W-1:0];
      p2s_pkg::REG_CHANNEL_COUNT: chans_r  = value[p2s_pkg::CHAN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(int mode, int w, int h, int c);
    write_reg(p2s_pkg::REG_POOL_MODE, mode);
    write_reg(p2s_pkg::REG_IMAGE_WIDTH, w);
    write_reg(p2s_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(p2s_pkg::REG_CHANNEL_COUNT, c);
  endtask

  task automatic run_frames(int frames, output int count);
    count = eff_width(int'(width_r)) * eff_height(int'(height_r)) *
            eff_chans(int'(chans_r)) * frames;
    repeat (count) push_pixel(rand_pixel());
  endtask

  // complete the frame in progress one element at a time
  task automatic finish_frame();
    while (ch_pos != 0 || col_pos != 0 || row_pos != 0) begin
      push_pixel(rand_pixel());
      while (pixels_taken != pixels_sent) @(posedge clk);
    end
  endtask

  task automatic random_setup();
    int wr, hr, cr;
    do begin
      if ($urandom_range(9) == 0) begin
        wr = $urandom_range(255);
        hr = $urandom_range(2047);
        cr = $urandom_range(127);
      end else begin
        wr = 2 * $urandom_range(1, 8);
        hr = 2 * $urandom_range(1, 4);
        cr = $urandom_range(1, 6);
      end
    end while (eff_width(wr) * eff_height(hr) * eff_chans(cr) > 80);
    set_geometry($urandom_range(1) ? p2s_pkg::MODE_AVG : p2s_pkg::MODE_MAX, wr, hr, cr);
  endtask

  initial begin
    int count, phase_items;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.pixel_value = '0;
    out_ch.ready      = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry, max then average extremes and rounding
    foreach (seed_max[i]) push_pixel(PIX_W'(seed_max[i]));
    drain();
    write_reg(p2s_pkg::REG_POOL_MODE, p2s_pkg::MODE_AVG);
    foreach (seed_avg[i]) push_pixel(PIX_W'(seed_avg[i]));
    drain();

    // mode flipped inside an open window
    for (int k = 0; k < 4; k++) begin
      set_geometry(k[0] ? p2s_pkg::MODE_AVG : p2s_pkg::MODE_MAX, 2, 2, 1);
      repeat (3) push_pixel(PIX_W'(k[1] ? p2s_pkg::PIX_MIN : p2s_pkg::PIX_MAX));
      drain();
      write_reg(p2s_pkg::REG_POOL_MODE, k[0] ? p2s_pkg::MODE_MAX : p2s_pkg::MODE_AVG);
      push_pixel(rand_pixel());
      drain();
    end

    // out-of-range register values
    send_idle_pct  = 26;
    recv_stall_pct = 26;
    set_geometry(p2s_pkg::MODE_MAX, 0, 1, 0);
    run_frames(2, count);
    drain();
    set_geometry(p2s_pkg::MODE_AVG, 1, 3, 2);
    run_frames(1, count);
    drain();
    set_geometry(p2s_pkg::MODE_MAX, 255, 2, 1);
    run_frames(1, count);
    drain();
    set_geometry(p2s_pkg::MODE_AVG, 3, 0, 127);
    run_frames(1, count);
    drain();
    set_geometry(p2s_pkg::MODE_AVG, 7, 5, 3);
    run_frames(1, count);
    drain();
    set_geometry(p2s_pkg::MODE_MAX, 2, 2047, 1);
    repeat (12) push_pixel(rand_pixel());
    drain();
    write_reg(p2s_pkg::REG_IMAGE_HEIGHT, 2);
    finish_frame();
    drain();

    // geometry changed mid-frame
    set_geometry(p2s_pkg::MODE_MAX, 8, 4, 3);
    repeat (60) push_pixel(rand_pixel());
    drain();
    write_reg(p2s_pkg::REG_IMAGE_WIDTH, 4);
    finish_frame();
    drain();
    set_geometry(p2s_pkg::MODE_AVG, 4, 2, 4);
    repeat (2) push_pixel(rand_pixel());
    drain();
    write_reg(p2s_pkg::REG_CHANNEL_COUNT, 1);
    finish_frame();
    drain();
    set_geometry(p2s_pkg::MODE_MAX, 2, 8, 1);
    repeat (8) push_pixel(rand_pixel());
    drain();
    write_reg(p2s_pkg::REG_IMAGE_HEIGHT, 2);
    finish_frame();
    drain();
    set_geometry(p2s_pkg::MODE_AVG, 4, 4, 2);
    repeat (16) push_pixel(rand_pixel());
    drain();
    write_reg(p2s_pkg::REG_IMAGE_WIDTH, 6);
    write_reg(p2s_pkg::REG_CHANNEL_COUNT, 3);
    write_reg(p2s_pkg::REG_IMAGE_HEIGHT, 6);
    finish_frame();
    drain();

    // receiver holds off while the sender keeps offering
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_geometry(p2s_pkg::MODE_MAX, 8, 4, 4);
    @(posedge clk);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    run_frames(1, count);
    drain();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = stall_pcts[p];
      phase_items    = 0;
      while (phase_items < 60) begin
        drain();
        random_setup();
        run_frames(1, count);
        phase_items += count;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    mismatch_count += pooled_expect.size();
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/p2s_pkg.sv
rtl/core/p2s_in_if.sv
rtl/core/p2s_out_if.sv
rtl/core/p2s_pos.sv
rtl/core/p2s_store.sv
rtl/core/pool_2x2_stream_int8.sv
dv/tb_pool_2x2_stream_int8.sv
